/* rtl/core/dvfs_level_vote_aggregator_defines.svh */
// Assertion macros for the DVFS level vote aggregator.
// Included by RTL files that carry concurrent assertions; no dependencies.
`ifndef DVFS_LEVEL_VOTE_AGGREGATOR_DEFINES_SVH
`define DVFS_LEVEL_VOTE_AGGREGATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define DVA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dva assertion failed");
`define DVA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dva assertion failed");
`else
`define DVA_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define DVA_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/dva_pkg.sv */
// Package for the DVFS level vote aggregator: codes, shared types, frequency tables.
// No dependencies.
`default_nettype none
package dva_pkg;

    localparam int LEVELS_DEF      = 8;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int LVL_W           = 4;
    localparam int REG_ADDR_W      = 4;
    localparam int REG_DATA_W      = 32;

    localparam logic [3:0] OP_BUSY      = 4'd0;
    localparam logic [3:0] OP_IDLE      = 4'd1;
    localparam logic [3:0] OP_DVFS_OFF  = 4'd2;
    localparam logic [3:0] OP_DVFS_ON   = 4'd3;
    localparam logic [3:0] OP_BOOT      = 4'd4;
    localparam logic [3:0] OP_MAX       = 4'd5;
    localparam logic [3:0] OP_MIN       = 4'd6;
    localparam logic [3:0] OP_BOOST_ON  = 4'd7;
    localparam logic [3:0] OP_BOOST_OFF = 4'd8;
    localparam logic [3:0] OP_POWER_ON  = 4'd9;
    localparam logic [3:0] OP_CLOSE     = 4'd10;

    localparam logic [2:0] STS_OK           = 3'd0;
    localparam logic [2:0] STS_BAD_LEVEL    = 3'd1;
    localparam logic [2:0] STS_NOT_HELD     = 3'd2;
    localparam logic [2:0] STS_NOT_DISABLED = 3'd3;
    localparam logic [2:0] STS_OVERFLOW     = 3'd4;

    localparam logic [1:0] REG_DNC_FORCE = 2'd0;
    localparam logic [1:0] REG_DSP_FORCE = 2'd1;
    localparam logic [1:0] REG_BOOT      = 2'd2;

    typedef struct packed {
        logic capture;
        logic rd;
        logic ex;
    } t_cmd;

    typedef struct packed {
        logic signed [3:0] dnc_force;
        logic signed [3:0] dsp_force;
        logic [2:0]        boot;
    } t_cfg;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] dnc_level;
        logic [2:0] dsp_level;
        logic [9:0] dnc_freq_mhz;
        logic [9:0] dsp_freq_mhz;
        logic       mif_floor_high;
        logic       boost_active;
        logic       dvfs_active;
        logic       levels_changed;
    } t_res;

    function automatic logic [9:0] dnc_mhz(logic [2:0] lv);
        logic [9:0] f;
        case (lv)
            3'd0:    f = 10'd800;
            3'd1:    f = 10'd666;
            3'd2:    f = 10'd533;
            3'd3:    f = 10'd466;
            3'd4:    f = 10'd400;
            3'd5:    f = 10'd333;
            3'd6:    f = 10'd266;
            default: f = 10'd100;
        endcase
        return f;
    endfunction

    function automatic logic [9:0] dsp_mhz(logic [2:0] lv);
        logic [9:0] f;
        case (lv)
            3'd0:    f = 10'd933;
            3'd1:    f = 10'd800;
            3'd2:    f = 10'd666;
            3'd3:    f = 10'd533;
            3'd4:    f = 10'd400;
            3'd5:    f = 10'd333;
            3'd6:    f = 10'd200;
            default: f = 10'd100;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/dva_if.sv */
// Valid/ready channel interfaces for events in and results out.
// No dependencies.
`default_nettype none
interface dva_evt_if;
    logic       valid;
    logic       ready;
    logic [3:0] opcode;
    logic [3:0] level;
    logic       domain_running;

    modport source (output valid, output opcode, output level, output domain_running,
                    input ready);
    modport sink   (input valid, input opcode, input level, input domain_running,
                    output ready);
endinterface

interface dva_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [2:0] dnc_level;
    logic [2:0] dsp_level;
    logic [9:0] dnc_freq_mhz;
    logic [9:0] dsp_freq_mhz;
    logic       mif_floor_high;
    logic       boost_active;
    logic       dvfs_active;
    logic       levels_changed;

    modport source (output valid, output status, output dnc_level, output dsp_level,
                    output dnc_freq_mhz, output dsp_freq_mhz, output mif_floor_high,
                    output boost_active, output dvfs_active, output levels_changed,
                    input ready);
    modport sink   (input valid, input status, input dnc_level, input dsp_level,
                    input dnc_freq_mhz, input dsp_freq_mhz, input mif_floor_high,
                    input boost_active, input dvfs_active, input levels_changed,
                    output ready);
endinterface
`default_nettype wire

/* rtl/core/dva_regs.sv */
// APB configuration registers: force levels and boot level.
// Depends on dva_pkg.
`default_nettype none
module dva_regs
    import dva_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [REG_ADDR_W-1:0] paddr,
    input  wire logic [REG_DATA_W-1:0] pwdata,
    output logic      [REG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  i_clr_force,
    output t_cfg                       o_cfg
);

    logic signed [3:0] r_dnc_force;
    logic signed [3:0] r_dsp_force;
    logic [2:0]        r_boot;
    logic [1:0]        reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dnc_force <= -4'sd1;
            r_dsp_force <= -4'sd1;
            r_boot      <= 3'd0;
        end else if (i_clr_force) begin
            r_dnc_force <= -4'sd1;
            r_dsp_force <= -4'sd1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DNC_FORCE: r_dnc_force <= signed'(pwdata[3:0]);
                REG_DSP_FORCE: r_dsp_force <= signed'(pwdata[3:0]);
                REG_BOOT:      r_boot      <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DNC_FORCE: prdata = REG_DATA_W'(r_dnc_force);
            REG_DSP_FORCE: prdata = REG_DATA_W'(r_dsp_force);
            REG_BOOT:      prdata = REG_DATA_W'(r_boot);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = '{dnc_force: r_dnc_force, dsp_force: r_dsp_force, boot: r_boot};

endmodule
`default_nettype wire

/* rtl/core/dva_ctrl.sv */
// Sequencer: accept, count read, execute/write back, result handoff.
// Depends on dva_pkg.
`default_nettype none
module dva_ctrl
    import dva_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_evt_valid,
    output logic      o_evt_ready,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    output t_cmd      o_cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_EX} t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   accept;
    logic   ex_go;

    assign accept = i_evt_valid && r_in_ready;
    assign ex_go  = (r_state == ST_EX) && (!r_out_valid || i_res_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state    <= ST_RD;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_RD: begin
                    r_state <= ST_EX;
                end
                ST_EX: begin
                    if (ex_go) begin
                        r_state     <= ST_IDLE;
                        r_in_ready  <= 1'b1;
                        r_out_valid <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_evt_ready = r_in_ready;
    assign o_res_valid = r_out_valid;
    assign o_cmd       = '{capture: accept, rd: (r_state == ST_RD), ex: ex_go};

endmodule
`default_nettype wire

/* rtl/core/dva_dp.sv */
// Datapath: vote count memory, occupancy masks, totals, current levels, result register.
// Depends on dva_pkg and the assertion macro header.
`default_nettype none
`include "dvfs_level_vote_aggregator_defines.svh"
module dva_dp
    import dva_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire logic [3:0] i_opcode,
    input  wire logic [3:0] i_level,
    input  wire logic       i_domain_running,
    input  wire t_cfg       i_cfg,
    output logic            o_clr_force,
    output t_res            o_res
);

    localparam int LW    = $clog2(LEVELS);
    localparam int DEPTH = 2 ** (LW + 1);
    localparam logic [4:0]             LEVELS_C = 5'(LEVELS);
    localparam logic [LW-1:0]          SLOWEST  = LW'(LEVELS - 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_rdata;

    logic [3:0]             r_op;
    logic [3:0]             r_lv;
    logic                   r_bad;
    logic                   r_run;

    logic [LEVELS-1:0]      r_dmask, r_smask, n_dmask, n_smask;
    logic [COUNT_WIDTH-1:0] r_dtot, r_stot, n_dtot, n_stot;
    logic [LW-1:0]          r_dnc_cur, r_dsp_cur, n_dnc_cur, n_dsp_cur;
    logic                   r_boost, n_boost;
    t_res                   r_res, n_res;

    logic                   sel_static;
    logic [LW-1:0]          idx;
    logic [LW:0]            addr;
    logic                   held;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] tot;
    logic                   can_add;
    logic                   scaling;
    logic                   do_add, do_del;
    logic [COUNT_WIDTH-1:0] wdata;
    logic [LW-1:0]          dbest, sbest;
    logic [2:0]             sts;
    logic                   clr;
    logic [3:0]             dnc4, dsp4;

    function automatic logic [LW-1:0] best_of(logic [LEVELS-1:0] m);
        logic [LW-1:0] b;
        b = SLOWEST;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (m[i]) begin
                b = LW'(i);
            end
        end
        return b;
    endfunction

    function automatic logic [3:0] pick(logic signed [3:0] f, logic [3:0] fb);
        return f[3] ? fb : f;
    endfunction

    function automatic logic [LW-1:0] apply(logic [LW-1:0] cur, logic [3:0] v, logic run);
        logic [LW-1:0] r;
        r = cur;
        if (run && ({1'b0, v} < LEVELS_C)) begin
            r = v[LW-1:0];
        end
        return r;
    endfunction

    function automatic logic [LW-1:0] power_level(logic signed [3:0] f, logic scal,
                                                  logic [LW-1:0] sb);
        logic [LW-1:0] r;
        if (f[3]) begin
            r = scal ? SLOWEST : sb;
        end else if ({1'b0, f} >= LEVELS_C) begin
            r = SLOWEST;
        end else begin
            r = f[LW-1:0];
        end
        return r;
    endfunction

    assign sel_static = (r_op == OP_DVFS_OFF) || (r_op == OP_DVFS_ON) ||
                        (r_op == OP_BOOST_ON) || (r_op == OP_BOOST_OFF);
    assign idx  = r_lv[LW-1:0];
    assign addr = {sel_static, idx};

    // capture event, read the count and write it back
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_lv  <= ((i_opcode == OP_BOOST_ON) || (i_opcode == OP_BOOST_OFF)) ?
                     4'd0 : i_level;
            r_bad <= (i_opcode <= OP_DVFS_ON) && ({1'b0, i_level} >= LEVELS_C);
            r_run <= i_domain_running;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[addr];
        end
        if (i_cmd.ex && (do_add || do_del)) begin
            mem[addr] <= wdata;
        end
    end

    always_comb begin
        // a clear mask bit means a zero count, whatever the memory holds
        held    = sel_static ? r_smask[idx] : r_dmask[idx];
        cnt     = held ? r_rdata : '0;
        tot     = sel_static ? r_stot : r_dtot;
        can_add = (cnt != CNT_MAX) && (tot != CNT_MAX);
        scaling = (r_stot == '0);

        sts    = STS_OK;
        do_add = 1'b0;
        do_del = 1'b0;
        clr    = 1'b0;
        n_boost = r_boost;

        if (r_bad) begin
            sts = STS_BAD_LEVEL;
        end else begin
            case (r_op) inside
                OP_BUSY, OP_DVFS_OFF, OP_BOOST_ON: begin
                    if (!can_add) begin
                        sts = STS_OVERFLOW;
                    end else begin
                        do_add = 1'b1;
                        if (r_op == OP_BOOST_ON) begin
                            n_boost = 1'b1;
                        end
                    end
                end
                OP_IDLE: begin
                    if (!held) begin
                        sts = STS_NOT_HELD;
                    end else begin
                        do_del = 1'b1;
                    end
                end
                OP_DVFS_ON, OP_BOOST_OFF: begin
                    if (r_op == OP_BOOST_OFF) begin
                        n_boost = 1'b0;
                    end
                    if (r_stot == '0) begin
                        sts = STS_NOT_DISABLED;
                    end else if (!held) begin
                        sts = STS_NOT_HELD;
                    end else begin
                        do_del = 1'b1;
                    end
                end
                OP_CLOSE: clr = 1'b1;
                default: ;
            endcase
        end

        n_dmask = r_dmask;
        n_smask = r_smask;
        n_dtot  = r_dtot;
        n_stot  = r_stot;
        wdata   = do_add ? cnt + 1'b1 : cnt - 1'b1;
        if (do_add || do_del) begin
            if (sel_static) begin
                n_smask[idx] = do_add || (cnt != COUNT_WIDTH'(1));
                n_stot       = do_add ? r_stot + 1'b1 : r_stot - 1'b1;
            end else begin
                n_dmask[idx] = do_add || (cnt != COUNT_WIDTH'(1));
                n_dtot       = do_add ? r_dtot + 1'b1 : r_dtot - 1'b1;
            end
        end
        if (clr) begin
            n_dmask = '0;
            n_smask = '0;
            n_dtot  = '0;
            n_stot  = '0;
        end

        dbest = best_of(n_dmask);
        sbest = best_of(n_smask);

        n_dnc_cur = r_dnc_cur;
        n_dsp_cur = r_dsp_cur;
        if (!r_bad) begin
            case (r_op) inside
                OP_BUSY: begin
                    if (do_add && scaling) begin
                        n_dnc_cur = apply(r_dnc_cur, pick(i_cfg.dnc_force, 4'(dbest)), r_run);
                        n_dsp_cur = apply(r_dsp_cur, pick(i_cfg.dsp_force, 4'(dbest)), r_run);
                    end
                end
                OP_IDLE: begin
                    if (scaling) begin
                        n_dnc_cur = apply(r_dnc_cur, 4'(dbest), r_run);
                        n_dsp_cur = apply(r_dsp_cur, 4'(dbest), r_run);
                    end
                end
                OP_DVFS_OFF, OP_BOOST_ON: begin
                    if (do_add) begin
                        n_dnc_cur = apply(r_dnc_cur, pick(i_cfg.dnc_force, 4'(sbest)), r_run);
                        n_dsp_cur = apply(r_dsp_cur, pick(i_cfg.dsp_force, 4'(sbest)), r_run);
                    end
                end
                OP_DVFS_ON, OP_BOOST_OFF: begin
                    if (do_del) begin
                        if (n_stot != '0) begin
                            n_dnc_cur = apply(r_dnc_cur, pick(i_cfg.dnc_force, 4'(sbest)),
                                              r_run);
                            n_dsp_cur = apply(r_dsp_cur, pick(i_cfg.dsp_force, 4'(sbest)),
                                              r_run);
                        end else begin
                            n_dnc_cur = apply(r_dnc_cur, 4'(dbest), r_run);
                            n_dsp_cur = apply(r_dsp_cur, 4'(dbest), r_run);
                        end
                    end
                end
                OP_BOOT: begin
                    if (scaling) begin
                        n_dnc_cur = apply(r_dnc_cur, pick(i_cfg.dnc_force, 4'(i_cfg.boot)),
                                          r_run);
                        n_dsp_cur = apply(r_dsp_cur, pick(i_cfg.dsp_force, 4'(i_cfg.boot)),
                                          r_run);
                    end
                end
                OP_MAX: begin
                    if (scaling) begin
                        n_dnc_cur = apply(r_dnc_cur, 4'd0, r_run);
                        n_dsp_cur = apply(r_dsp_cur, 4'd0, r_run);
                    end
                end
                OP_MIN: begin
                    if (scaling) begin
                        n_dnc_cur = SLOWEST;
                        n_dsp_cur = SLOWEST;
                        if (!r_run) begin
                            n_dnc_cur = r_dnc_cur;
                            n_dsp_cur = r_dsp_cur;
                        end
                    end
                end
                OP_POWER_ON: begin
                    n_dnc_cur = power_level(i_cfg.dnc_force, scaling, sbest);
                    n_dsp_cur = power_level(i_cfg.dsp_force, scaling, sbest);
                end
                default: ;
            endcase
        end

        dnc4 = 4'(n_dnc_cur);
        dsp4 = 4'(n_dsp_cur);
        n_res.status         = sts;
        n_res.dnc_level      = dnc4[2:0];
        n_res.dsp_level      = dsp4[2:0];
        n_res.dnc_freq_mhz   = dnc_mhz(dnc4[3] ? 3'd7 : dnc4[2:0]);
        n_res.dsp_freq_mhz   = dsp_mhz(dsp4[3] ? 3'd7 : dsp4[2:0]);
        n_res.mif_floor_high = (n_dsp_cur == '0);
        n_res.boost_active   = n_boost;
        // scaling is on exactly while no static vote is held
        n_res.dvfs_active    = (n_stot == '0);
        n_res.levels_changed = (n_dnc_cur != r_dnc_cur) || (n_dsp_cur != r_dsp_cur);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmask   <= '0;
            r_smask   <= '0;
            r_dtot    <= '0;
            r_stot    <= '0;
            r_dnc_cur <= SLOWEST;
            r_dsp_cur <= SLOWEST;
            r_boost   <= 1'b0;
        end else if (i_cmd.ex) begin
            r_dmask   <= n_dmask;
            r_smask   <= n_smask;
            r_dtot    <= n_dtot;
            r_stot    <= n_stot;
            r_dnc_cur <= n_dnc_cur;
            r_dsp_cur <= n_dsp_cur;
            r_boost   <= n_boost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ex) begin
            r_res <= n_res;
        end
    end

    assign o_res       = r_res;
    assign o_clr_force = i_cmd.ex && clr;

    `DVA_ASSERT_IMP(a_dyn_mask_tot, i_clk, i_rst_n, 1'b1, (r_dmask == '0) == (r_dtot == '0))
    `DVA_ASSERT_IMP(a_stat_mask_tot, i_clk, i_rst_n, 1'b1, (r_smask == '0) == (r_stot == '0))
    `DVA_ASSERT_IMP(a_cur_range, i_clk, i_rst_n, 1'b1, (r_dnc_cur < LEVELS) && (r_dsp_cur < LEVELS))
    `DVA_ASSERT_NXT(a_close_clears, i_clk, i_rst_n, i_cmd.ex && (r_op == OP_CLOSE), (r_smask == '0) && (r_dmask == '0))

endmodule
`default_nettype wire

/* rtl/core/dvfs_level_vote_aggregator.sv */
// An event passes the count read and execute states on its way from transfer to result valid.
// A new event is accepted only once the last has executed (vote count read-modify-write).
// A pending result that is not taken holds the next event in its execute cycle.
// Reset: synchronous, active low; clears votes, totals and boost, levels go to slowest.
// Count memory needs no clearing pass: per-level occupancy bits mark live entries.
`default_nettype none
module dvfs_level_vote_aggregator
    import dva_pkg::*;
#(
    parameter int LEVELS      = LEVELS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    dva_evt_if.sink                    i_evt,
    dva_res_if.source                  o_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [REG_ADDR_W-1:0] paddr,
    input  wire logic [REG_DATA_W-1:0] pwdata,
    output logic      [REG_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_cmd cmd;
    t_cfg cfg;
    t_res res;
    logic clr_force;
    logic evt_ready;
    logic res_valid;

    dva_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_clr_force (clr_force),
        .o_cfg       (cfg)
    );

    dva_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (i_evt.valid),
        .o_evt_ready (evt_ready),
        .o_res_valid (res_valid),
        .i_res_ready (o_res.ready),
        .o_cmd       (cmd)
    );

    dva_dp #(
        .LEVELS      (LEVELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_opcode         (i_evt.opcode),
        .i_level          (i_evt.level),
        .i_domain_running (i_evt.domain_running),
        .i_cfg            (cfg),
        .o_clr_force      (clr_force),
        .o_res            (res)
    );

    assign i_evt.ready          = evt_ready;
    assign o_res.valid          = res_valid;
    assign o_res.status         = res.status;
    assign o_res.dnc_level      = res.dnc_level;
    assign o_res.dsp_level      = res.dsp_level;
    assign o_res.dnc_freq_mhz   = res.dnc_freq_mhz;
    assign o_res.dsp_freq_mhz   = res.dsp_freq_mhz;
    assign o_res.mif_floor_high = res.mif_floor_high;
    assign o_res.boost_active   = res.boost_active;
    assign o_res.dvfs_active    = res.dvfs_active;
    assign o_res.levels_changed = res.levels_changed;

endmodule
`default_nettype wire
